// File: rtl/exlex_pkg.sv
// Shared types, token codes and keyword tables for the expression lexer.
`timescale 1ns / 1ps

package exlex_pkg;

    // Token kinds
    localparam logic [2:0] KIND_OP   = 3'd0;
    localparam logic [2:0] KIND_FUNC = 3'd1;
    localparam logic [2:0] KIND_NUM  = 3'd2;
    localparam logic [2:0] KIND_VAR  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Operator codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POW   = 3'd4;
    localparam logic [2:0] OP_OPEN  = 3'd5;
    localparam logic [2:0] OP_CLOSE = 3'd6;
    localparam logic [2:0] OP_EOL   = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_CHAR = 3'd0;
    localparam logic [2:0] ERR_LONG = 3'd1;
    localparam logic [2:0] ERR_FULL = 3'd2;

    // Lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_OVL  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2a;
    localparam logic [7:0] CH_ADD   = 8'h2b;
    localparam logic [7:0] CH_SUB   = 8'h2d;
    localparam logic [7:0] CH_DIV   = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POW   = 8'h5e;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;

    // Built-in function names
    localparam int FUNC_COUNT = 5;

    // One pending token job: a ready token, or a word that needs a lookup
    typedef struct packed {
        logic        srch;
        logic [2:0]  kind;
        logic [2:0]  code;
        logic [31:0] value;
    } t_job;

    // Letter of function name idx at position pos, zero past its end
    function automatic logic [7:0] func_char(input logic [2:0] idx, input logic [7:0] pos);
        logic [23:0] txt;
        logic [7:0]  ch;
        case (idx)
            3'd0: txt = "sin";
            3'd1: txt = "cos";
            3'd2: txt = "tan";
            3'd3: txt = "ctg";
            3'd4: txt = {"ln", 8'h00};
            default: txt = 24'd0;
        endcase
        case (pos)
            8'd0: ch = txt[23:16];
            8'd1: ch = txt[15:8];
            8'd2: ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Length of function name idx
    function automatic logic [1:0] func_len(input logic [2:0] idx);
        logic [1:0] len;
        len = (idx == 3'd4) ? 2'd2 : 2'd3;
        return len;
    endfunction

endpackage

// File: rtl/expression_lexer_with_interning_core.sv
// Expression lexer: tokenizes text bytes and interns variable names.
//
//  channel   dir  tdata                                   tuser       tlast
//  s_axis    in   [7:0] character                         -           end_of_text
//  m_axis    out  [2:0] code, [34:3] number, [38:35] var  [2:0] kind  last_of_run
//
// A byte that makes no token leaves the intake open; each ready token waits for a free output register.
// A word end runs a lookup on the shared byte comparator: it dispatches and checks
// the function names; on no match it reads and checks the length of each table entry
// and each byte of entries with the same length, claims a slot for a name not found
// while the table has room, then emits the result (the name table reads are registered).
// Reset clears the mode, accumulator, counters and output valid; the name memories
// need no clearing pass. A full output register holds the sequencer, and the intake
// stays closed while the sequencer still has tokens of the last byte to emit.
`timescale 1ns / 1ps

module expression_lexer_with_interning_core
    import exlex_pkg::*;
#(
    parameter int MAX_VARIABLES = 16,
    parameter int MAX_NAME_LEN  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] character
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [2:0] token_code, [34:3] number_value,
                                          // [38:35] variable_index, [39] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    localparam int VIW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
    localparam int CW  = $clog2(MAX_VARIABLES + 1);
    localparam int WLW = $clog2(MAX_NAME_LEN + 1);
    localparam int LW  = $clog2(MAX_NAME_LEN);
    localparam int NS  = (MAX_VARIABLES + 1) * MAX_NAME_LEN;
    localparam int AW  = $clog2(NS);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_JOB      = 3'd1;
    localparam logic [2:0] ST_FUNC     = 3'd2;
    localparam logic [2:0] ST_LEN_RD   = 3'd3;
    localparam logic [2:0] ST_LEN_CHK  = 3'd4;
    localparam logic [2:0] ST_BYTE_RD  = 3'd5;
    localparam logic [2:0] ST_BYTE_CHK = 3'd6;
    localparam logic [2:0] ST_PUT      = 3'd7;

    // Sequencer and lexer state
    logic [2:0]            r_state;
    logic [1:0]            r_mode;
    logic [31:0]           r_acc;
    logic [WLW-1:0]        r_wlen;
    logic [FUNC_COUNT-1:0] r_fm;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_cur_base;
    logic [1:0]            r_njobs;
    logic                  r_jsel;
    logic [CW-1:0]         r_i;
    logic [AW-1:0]         r_base;
    logic [LW-1:0]         r_j;
    logic                  r_out_valid;

    // Payload registers
    t_job                  r_job [2];
    logic [WLW-1:0]        r_slen;
    logic [FUNC_COUNT-1:0] r_sfm;
    logic [2:0]            r_res_kind;
    logic [2:0]            r_res_code;
    logic [3:0]            r_res_vi;
    logic [2:0]            r_out_kind;
    logic [2:0]            r_out_code;
    logic [31:0]           r_out_value;
    logic [3:0]            r_out_vi;
    logic                  r_out_last;

    // Name memories
    logic [7:0]            r_name_mem [NS];
    logic [WLW-1:0]        r_len_mem [MAX_VARIABLES];
    logic [7:0]            r_rd_a;
    logic [7:0]            r_rd_b;
    logic [WLW-1:0]        r_len_rd;

    // Accept-side next values
    logic [1:0]            n_mode;
    logic [31:0]           n_acc;
    logic [WLW-1:0]        n_wlen;
    logic [FUNC_COUNT-1:0] n_fm;
    logic [WLW-1:0]        n_slen;
    logic [FUNC_COUNT-1:0] n_sfm;
    logic [1:0]            n_njobs;
    t_job                  n_job0;
    t_job                  n_job1;

    logic                  s_accept;
    logic [7:0]            c;
    logic                  is_digit;
    logic                  is_lower;
    logic                  name_we;
    logic [AW-1:0]         name_waddr;
    logic [AW-1:0]         addr_a;
    logic [AW-1:0]         addr_b;
    logic                  len_we;
    logic                  out_free;
    logic                  out_load;
    logic [2:0]            out_kind;
    logic [2:0]            out_code;
    logic [31:0]           out_value;
    logic [3:0]            out_vi;
    logic                  job_last;
    t_job                  cur_job;
    logic                  func_hit;
    logic [2:0]            func_code;
    logic                  table_end;
    logic                  table_full;
    logic                  byte_last;

    // Token job for flushing a pending run
    function automatic t_job flush_job(input logic [1:0] mode, input logic [31:0] acc);
        t_job j;
        j.srch  = (mode == MODE_WORD);
        j.kind  = (mode == MODE_NUM) ? KIND_NUM : KIND_ERR;
        j.code  = (mode == MODE_NUM) ? 3'd0 : ERR_LONG;
        j.value = (mode == MODE_NUM) ? acc : 32'd0;
        return j;
    endfunction

    assign s_accept        = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign c               = i_s_axis_tdata;
    assign is_digit        = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_lower        = (c >= CH_LOW_A) && (c <= CH_LOW_Z);

    // Classify the byte, update the run and build up to two token jobs
    always_comb begin
        logic                  v0;
        logic                  v1;
        logic                  v2;
        logic [1:0]            mode_a;
        logic [31:0]           acc_a;
        logic [WLW-1:0]        wlen_a;
        logic [FUNC_COUNT-1:0] fm_a;
        logic [1:0]            mode_b;
        logic [31:0]           acc_b;
        logic [WLW-1:0]        wlen_b;
        logic [FUNC_COUNT-1:0] fm_b;
        t_job                  j0;
        t_job                  j1;
        t_job                  j2;

        v0 = ((r_mode == MODE_NUM) && !is_digit) ||
             (((r_mode == MODE_WORD) || (r_mode == MODE_OVL)) && !is_lower);
        j0 = flush_job(r_mode, r_acc);

        mode_a = v0 ? MODE_IDLE : r_mode;
        acc_a  = v0 ? 32'd0 : r_acc;
        wlen_a = v0 ? '0 : r_wlen;
        fm_a   = r_fm;

        mode_b  = mode_a;
        acc_b   = acc_a;
        wlen_b  = wlen_a;
        fm_b    = fm_a;
        name_we = 1'b0;
        v1      = 1'b0;
        j1      = '{srch: 1'b0, kind: KIND_OP, code: OP_ADD, value: 32'd0};

        if (is_digit) begin
            mode_b = MODE_NUM;
            acc_b  = (acc_a << 3) + (acc_a << 1) + {28'd0, c[3:0]};
        end else if (is_lower) begin
            if (mode_a == MODE_IDLE) begin
                mode_a = MODE_WORD;
                wlen_a = '0;
                fm_a   = '1;
            end
            mode_b = mode_a;
            fm_b   = fm_a;
            if (mode_a == MODE_WORD) begin
                if (wlen_a < WLW'(MAX_NAME_LEN)) begin
                    name_we = s_accept;
                    wlen_b  = wlen_a + WLW'(1);
                    for (int k = 0; k < FUNC_COUNT; k++) begin
                        fm_b[k] = fm_a[k] && (func_char(3'(k), 8'(wlen_a)) == c);
                    end
                end else begin
                    mode_b = MODE_OVL;
                end
            end
        end else begin
            v1 = 1'b1;
            case (c)
                CH_SPACE, CH_TAB: v1 = 1'b0;
                CH_ADD:   j1.code = OP_ADD;
                CH_SUB:   j1.code = OP_SUB;
                CH_MUL:   j1.code = OP_MUL;
                CH_DIV:   j1.code = OP_DIV;
                CH_POW:   j1.code = OP_POW;
                CH_OPEN:  j1.code = OP_OPEN;
                CH_CLOSE: j1.code = OP_CLOSE;
                CH_NUL:   j1.code = OP_EOL;
                default: begin
                    j1.kind = KIND_ERR;
                    j1.code = ERR_CHAR;
                end
            endcase
        end

        name_waddr = r_cur_base + AW'(wlen_a);

        v2 = i_s_axis_tlast && (mode_b != MODE_IDLE);
        j2 = flush_job(mode_b, acc_b);

        if (i_s_axis_tlast) begin
            n_mode = MODE_IDLE;
            n_acc  = 32'd0;
            n_wlen = '0;
        end else begin
            n_mode = mode_b;
            n_acc  = acc_b;
            n_wlen = wlen_b;
        end
        n_fm = fm_b;

        // Only one word lookup can arise from one byte
        if (v0 && (r_mode == MODE_WORD)) begin
            n_slen = r_wlen;
            n_sfm  = r_fm;
        end else begin
            n_slen = wlen_b;
            n_sfm  = fm_b;
        end

        n_njobs = 2'(v0) + 2'(v1) + 2'(v2);
        n_job0  = v0 ? j0 : (v1 ? j1 : j2);
        n_job1  = (v0 && v1) ? j1 : j2;
    end

    // Lookup helpers
    always_comb begin
        func_hit  = 1'b0;
        func_code = 3'd0;
        for (int k = 0; k < FUNC_COUNT; k++) begin
            if (r_sfm[k] && (r_slen == WLW'(func_len(3'(k))))) begin
                func_hit  = 1'b1;
                func_code = 3'(k);
            end
        end
    end

    assign table_end  = (r_i == r_count);
    assign table_full = (r_count == CW'(MAX_VARIABLES));
    assign byte_last  = ((WLW'(r_j) + WLW'(1)) == r_slen);
    assign len_we     = (r_state == ST_LEN_RD) && table_end && !table_full;
    assign addr_a     = r_base + AW'(r_j);
    assign addr_b     = r_cur_base + AW'(r_j);

    // Select what goes into the output register
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign cur_job  = r_job[r_jsel];
    assign job_last = r_jsel || (r_njobs == 2'd1);

    always_comb begin
        out_load  = 1'b0;
        out_kind  = cur_job.kind;
        out_code  = cur_job.code;
        out_value = cur_job.value;
        out_vi    = 4'd0;
        case (r_state)
            ST_JOB: out_load = out_free && !cur_job.srch;
            ST_PUT: begin
                out_load  = out_free;
                out_kind  = r_res_kind;
                out_code  = r_res_code;
                out_value = 32'd0;
                out_vi    = r_res_vi;
            end
            default: out_load = 1'b0;
        endcase
    end

    // Name memory: byte write at intake, two registered compare reads
    always_ff @(posedge i_clk) begin
        if (name_we) begin
            r_name_mem[name_waddr] <= c;
        end
        r_rd_a <= r_name_mem[addr_a];
        r_rd_b <= r_name_mem[addr_b];
    end

    // Name length memory
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[r_count[VIW-1:0]] <= r_slen;
        end
        r_len_rd <= r_len_mem[r_i[VIW-1:0]];
    end

    // Sequencer and lexer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_IDLE;
            r_acc       <= 32'd0;
            r_wlen      <= '0;
            r_fm        <= '0;
            r_count     <= '0;
            r_cur_base  <= '0;
            r_njobs     <= 2'd0;
            r_jsel      <= 1'b0;
            r_i         <= '0;
            r_base      <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_mode  <= n_mode;
                        r_acc   <= n_acc;
                        r_wlen  <= n_wlen;
                        r_fm    <= n_fm;
                        r_njobs <= n_njobs;
                        r_jsel  <= 1'b0;
                        if (n_njobs != 2'd0) begin
                            r_state <= ST_JOB;
                        end
                    end
                end
                ST_JOB: begin
                    if (cur_job.srch) begin
                        r_state <= ST_FUNC;
                    end else if (out_free) begin
                        if (job_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_jsel <= 1'b1;
                        end
                    end
                end
                ST_FUNC: begin
                    r_i    <= '0;
                    r_base <= '0;
                    r_state <= func_hit ? ST_PUT : ST_LEN_RD;
                end
                ST_LEN_RD: begin
                    if (table_end) begin
                        if (!table_full) begin
                            r_count    <= r_count + CW'(1);
                            r_cur_base <= r_cur_base + AW'(MAX_NAME_LEN);
                        end
                        r_state <= ST_PUT;
                    end else begin
                        r_state <= ST_LEN_CHK;
                    end
                end
                ST_LEN_CHK: begin
                    if (r_len_rd == r_slen) begin
                        r_j     <= '0;
                        r_state <= ST_BYTE_RD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_base  <= r_base + AW'(MAX_NAME_LEN);
                        r_state <= ST_LEN_RD;
                    end
                end
                ST_BYTE_RD: begin
                    r_state <= ST_BYTE_CHK;
                end
                ST_BYTE_CHK: begin
                    if (r_rd_a != r_rd_b) begin
                        r_i     <= r_i + CW'(1);
                        r_base  <= r_base + AW'(MAX_NAME_LEN);
                        r_state <= ST_LEN_RD;
                    end else if (byte_last) begin
                        r_state <= ST_PUT;
                    end else begin
                        r_j     <= r_j + LW'(1);
                        r_state <= ST_BYTE_RD;
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        if (job_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_jsel  <= 1'b1;
                            r_state <= ST_JOB;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload: jobs, lookup operands, lookup result and output register
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_job[0] <= n_job0;
            r_job[1] <= n_job1;
            r_slen   <= n_slen;
            r_sfm    <= n_sfm;
        end
        case (r_state)
            ST_FUNC: begin
                r_res_kind <= KIND_FUNC;
                r_res_code <= func_code;
                r_res_vi   <= 4'd0;
            end
            ST_LEN_RD: begin
                r_res_kind <= table_full ? KIND_ERR : KIND_VAR;
                r_res_code <= table_full ? ERR_FULL : 3'd0;
                r_res_vi   <= table_full ? 4'd0 : 4'(r_count);
            end
            ST_BYTE_CHK: begin
                r_res_kind <= KIND_VAR;
                r_res_code <= 3'd0;
                r_res_vi   <= 4'(r_i);
            end
            default: r_res_kind <= r_res_kind;
        endcase
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_code  <= out_code;
            r_out_value <= out_value;
            r_out_vi    <= out_vi;
            r_out_last  <= job_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_vi, r_out_value, r_out_code};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Table count never passes its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VARIABLES))
        else $error("variable count exceeds table capacity");

    // A byte that makes tokens closes the intake on the next cycle
    a_busy_after_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (n_njobs != 2'd0)) |=> !o_s_axis_tready)
        else $error("intake open while tokens are pending");

    // A lookup always has at least one letter
    a_word_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FUNC) |-> (r_slen != '0))
        else $error("lookup started on an empty word");

    // Byte compare stays inside the word
    a_byte_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BYTE_CHK) |-> (WLW'(r_j) < r_slen))
        else $error("byte compare beyond word length");

    // The second job slot is used only when two jobs are pending
    a_two_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_JOB && r_jsel) |-> (r_njobs == 2'd2))
        else $error("second job selected with a single job");
`endif

endmodule
